>>> sv/blbm_pkg.sv
// blbm_pkg: shared constants and types for the line-to-bitmask generator
`timescale 1ns / 1ps

package blbm_pkg;

    // coordinate and mask geometry
    localparam int COORD_BITS = 12;
    localparam int MASK_BITS  = 12;
    localparam int ADDR_BITS  = 22;

    // derived widths
    localparam int DIFF_BITS  = COORD_BITS + 1;   // signed endpoint difference
    localparam int DELTA_BITS = COORD_BITS + 2;   // doubled delta, unsigned
    localparam int ERR_BITS   = COORD_BITS + 3;   // signed error term
    localparam int CMP_BITS   = (COORD_BITS > MASK_BITS) ? COORD_BITS : MASK_BITS;
    localparam int PROD_BITS  = MASK_BITS + COORD_BITS - 1;

    // stream word layout
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + 1 + ADDR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic CFG_MASK_LENGTH = 1'b0;
    localparam logic CFG_MASK_HEIGHT = 1'b1;

    // reset values of the mask size registers
    localparam logic [MASK_BITS-1:0] MASK_LENGTH_RESET = MASK_BITS'(640);
    localparam logic [MASK_BITS-1:0] MASK_HEIGHT_RESET = MASK_BITS'(480);

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // one emitted point
    typedef struct packed {
        logic                         last;
        logic [ADDR_BITS-1:0]         addr;
        logic                         in_mask;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] px;
    } point_t;

endpackage

>>> sv/bresenham_line_to_bitmask.sv
// Bresenham line generator with mask clipping and bit addressing, top level
`timescale 1ns / 1ps

// One input word is taken per clock, at full rate even while a point waits
// at the output: the output stage holds a result register plus one skid
// entry, and s_tready drops only while the skid entry is full. A load word
// (tuser 0) latches a new line and gives no output; a step word (tuser 1)
// emits the current point into the output stage and advances the line
// by one unit along its major axis. The next-point logic, bounds checks and
// single 12 x 11 bit address multiply sit between the line state and output
// registers, so a new point can follow every cycle while s_tready is high.
// Step words while no line is active are dropped. The final point of a line
// carries tlast and returns the generator to idle.
module bresenham_line_to_bitmask
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [blbm_pkg::MASK_BITS-1:0]       cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: x_start, y_start, x_end, y_end (lowest bits first)
    input  logic [blbm_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // tuser: operation
    input  logic                                 s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: point_x, point_y, inside_res, pixel_address (lowest bits first)
    output logic [blbm_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                 m_tlast
);

    import blbm_pkg::*;

    // mask size registers
    logic [MASK_BITS-1:0] mask_length_reg;
    logic [MASK_BITS-1:0] mask_height_reg;

    // line state
    logic                         busy_reg,  busy_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic signed [ERR_BITS-1:0]   err_reg,   err_next;
    logic [DELTA_BITS-1:0]        dx2_reg,   dx2_next;
    logic [DELTA_BITS-1:0]        dy2_reg,   dy2_next;
    logic                         x_major_reg, x_major_next;
    logic                         y_down_reg,  y_down_next;

    // output stage
    logic   out_valid_reg;
    logic   skid_valid_reg;
    point_t out_reg;
    point_t skid_reg;

    // handshake
    logic s_accept;
    logic pop;
    logic push;

    // load decode
    logic signed [COORD_BITS-1:0] in_xs, in_ys, in_xe, in_ye;
    logic                         swap;
    logic signed [COORD_BITS-1:0] ld_x1, ld_y1, ld_x2, ld_y2;
    logic signed [DIFF_BITS-1:0]  ld_dx, ld_dy, ld_ady;
    logic [DELTA_BITS-1:0]        ld_dx2, ld_dy2;
    logic                         ld_x_major;

    // step datapath
    logic [DELTA_BITS-1:0]        minor_d, major_d;
    logic signed [ERR_BITS-1:0]   err_add;
    logic                         step_minor;
    logic signed [COORD_BITS-1:0] y_moved;
    logic signed [COORD_BITS-1:0] x_moved;
    logic                         fin;
    logic                         x_in, y_in, in_mask;
    logic [PROD_BITS-1:0]         prod;
    logic [ADDR_BITS-1:0]         addr;
    point_t                       point;

    // handshake decode
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign push     = s_accept && (s_tuser == OP_STEP) && busy_reg;

    // endpoint unpacking and ordering so x never decreases
    assign in_xs = s_tdata[COORD_BITS-1:0];
    assign in_ys = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_xe = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_ye = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign swap  = in_xs > in_xe;
    assign ld_x1 = swap ? in_xe : in_xs;
    assign ld_y1 = swap ? in_ye : in_ys;
    assign ld_x2 = swap ? in_xs : in_xe;
    assign ld_y2 = swap ? in_ys : in_ye;

    // doubled deltas and major axis choice
    always_comb
    begin
        ld_dx      = DIFF_BITS'(ld_x2) - DIFF_BITS'(ld_x1);
        ld_dy      = DIFF_BITS'(ld_y2) - DIFF_BITS'(ld_y1);
        ld_ady     = ld_dy[DIFF_BITS-1] ? -ld_dy : ld_dy;
        ld_dx2     = {1'b0, ld_dx} << 1;
        ld_dy2     = {1'b0, ld_ady} << 1;
        ld_x_major = ld_dx2 >= ld_dy2;
    end

    // next point along the line
    always_comb
    begin
        minor_d    = x_major_reg ? dy2_reg : dx2_reg;
        major_d    = x_major_reg ? dx2_reg : dy2_reg;
        err_add    = err_reg + $signed({1'b0, minor_d});
        step_minor = !err_add[ERR_BITS-1];
        y_moved    = y_down_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
        x_moved    = cur_x_reg + COORD_BITS'(1);
        fin        = (x_major_reg ? cur_x_reg : cur_y_reg) == major_end_reg;
    end

    // clipping and bit address of the current point
    always_comb
    begin
        x_in    = !cur_x_reg[COORD_BITS-1] &&
                  (CMP_BITS'(cur_x_reg[COORD_BITS-2:0]) < CMP_BITS'(mask_length_reg));
        y_in    = !cur_y_reg[COORD_BITS-1] &&
                  (CMP_BITS'(cur_y_reg[COORD_BITS-2:0]) < CMP_BITS'(mask_height_reg));
        in_mask = x_in && y_in;
        prod    = PROD_BITS'(mask_length_reg) * PROD_BITS'(cur_y_reg[COORD_BITS-2:0]);
        addr    = in_mask ? ADDR_BITS'(prod) + ADDR_BITS'(cur_x_reg[COORD_BITS-2:0])
                          : '0;
        point.px      = cur_x_reg;
        point.py      = cur_y_reg;
        point.in_mask = in_mask;
        point.addr    = addr;
        point.last    = fin;
    end

    // line state next values
    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        err_next       = err_reg;
        dx2_next       = dx2_reg;
        dy2_next       = dy2_reg;
        x_major_next   = x_major_reg;
        y_down_next    = y_down_reg;
        if (s_accept && (s_tuser == OP_LOAD))
        begin
            busy_next      = 1'b1;
            cur_x_next     = ld_x1;
            cur_y_next     = ld_y1;
            major_end_next = ld_x_major ? ld_x2 : ld_y2;
            err_next       = ld_x_major ? $signed({1'b0, ld_dy2}) - $signed({1'b0, ld_dx2})
                                        : $signed({1'b0, ld_dx2}) - $signed({1'b0, ld_dy2});
            dx2_next       = ld_dx2;
            dy2_next       = ld_dy2;
            x_major_next   = ld_x_major;
            y_down_next    = ld_dy[DIFF_BITS-1];
        end
        else if (push)
        begin
            if (fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                err_next = step_minor ? err_add - $signed({1'b0, major_d}) : err_add;
                if (x_major_reg)
                begin
                    cur_x_next = x_moved;
                    cur_y_next = step_minor ? y_moved : cur_y_reg;
                end
                else
                begin
                    cur_y_next = y_moved;
                    cur_x_next = step_minor ? x_moved : cur_x_reg;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_length_reg <= MASK_LENGTH_RESET;
            mask_height_reg <= MASK_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MASK_LENGTH: mask_length_reg <= cfg_data;
                CFG_MASK_HEIGHT: mask_height_reg <= cfg_data;
                default:         mask_length_reg <= mask_length_reg;
            endcase
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            err_reg       <= '0;
            dx2_reg       <= '0;
            dy2_reg       <= '0;
            x_major_reg   <= 1'b0;
            y_down_reg    <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            err_reg       <= err_next;
            dx2_reg       <= dx2_next;
            dy2_reg       <= dy2_next;
            x_major_reg   <= x_major_next;
            y_down_reg    <= y_down_next;
        end
    end

    // output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output and skid words
    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : point;
        end
        else if (push)
        begin
            skid_reg <= point;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'({out_reg.addr, out_reg.in_mask, out_reg.py, out_reg.px});
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    // a word in the skid entry always has one ahead of it
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // a load always leaves a line active
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser == OP_LOAD) |=> busy_reg)
        else $error("line not active after load");

    // emitting the final point ends the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && fin) |=> !busy_reg)
        else $error("line still active after final point");
`endif

endmodule
